### rtl/bresenham_line_pixel_generator_unit_assert.svh
// Assertion macros shared by the line rasterizer modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BLPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BLPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/blpg_pkg.sv
`default_nettype none

package blpg_pkg;

	localparam int unsigned COL_W = 10;
	localparam int unsigned ROW_W = 9;
	localparam int unsigned CLR_W = 8;
	localparam int unsigned ERR_W = 13;

	localparam int unsigned BLPG_QUEUE_DEPTH = 4;

	typedef enum logic {
		KIND_LINE    = 1'b0,
		KIND_ADVANCE = 1'b1
	} blpg_kind_t;

	typedef struct packed {
		logic             kind;
		logic [COL_W-1:0] start_x;
		logic [ROW_W-1:0] start_y;
		logic [COL_W-1:0] end_x;
		logic [ROW_W-1:0] end_y;
		logic [CLR_W-1:0] palette_index;
	} blpg_cmd_t;

	typedef struct packed {
		logic [COL_W-1:0] pixel_x;
		logic [ROW_W-1:0] pixel_y;
		logic [CLR_W-1:0] pixel_colour;
		logic             last;
	} blpg_pix_t;

	// Decoded item handed from the front to the back through the queue.
	typedef struct packed {
		logic                    is_line;
		logic [COL_W-1:0]        col;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        major;
		logic [COL_W-1:0]        minor;
		logic signed [ERR_W-1:0] err;
		logic                    col_nz;
		logic                    col_neg;
		logic                    row_nz;
		logic                    row_neg;
		logic                    steep;
		logic [CLR_W-1:0]        colour;
	} blpg_entry_t;

endpackage

`default_nettype wire

### rtl/blpg_front.sv
`default_nettype none

module blpg_front
	import blpg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire blpg_cmd_t   cmd,
	output logic             push_valid,
	input  wire logic        push_ready,
	output blpg_entry_t      push_entry
);

	logic              valid_s1;
	blpg_entry_t       entry_s1;
	blpg_entry_t       dec;
	logic [COL_W:0]    dx;
	logic [ROW_W:0]    dy;
	logic [COL_W-1:0]  adx;
	logic [COL_W-1:0]  ady;

	assign cmd_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	// Absolute deltas, octant and initial error term of a line command.
	always_comb begin
		dx  = {1'b0, cmd.end_x} - {1'b0, cmd.start_x};
		dy  = {1'b0, cmd.end_y} - {1'b0, cmd.start_y};
		adx = dx[COL_W] ? COL_W'(-dx) : dx[COL_W-1:0];
		ady = dy[ROW_W] ? COL_W'({1'b0, -dy}) : COL_W'(dy);

		dec.is_line = (blpg_kind_t'(cmd.kind) == KIND_LINE);
		dec.col     = cmd.start_x;
		dec.row     = cmd.start_y;
		dec.steep   = ady > adx;
		dec.major   = dec.steep ? ady : adx;
		dec.minor   = dec.steep ? adx : ady;
		dec.err     = ERR_W'({dec.minor, 1'b0}) - ERR_W'(dec.major);
		dec.col_nz  = |dx;
		dec.col_neg = dx[COL_W];
		dec.row_nz  = |dy;
		dec.row_neg = dy[ROW_W];
		dec.colour  = cmd.palette_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			entry_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

### rtl/blpg_queue.sv
`default_nettype none
`include "bresenham_line_pixel_generator_unit_assert.svh"

module blpg_queue
	import blpg_pkg::*;
#(
	parameter int unsigned DEPTH = BLPG_QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire blpg_entry_t  push_entry,
	output logic              pop_valid,
	input  wire logic         pop,
	output blpg_entry_t       pop_entry
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	blpg_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`BLPG_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`BLPG_ASSERT_NEXT(a_fill_on_push, do_push && !do_pop, count_q != '0, "push lost")
	`BLPG_ASSERT_NOW(a_ptr_match, count_q == '0, wr_ptr_q == rd_ptr_q, "pointers diverge when empty")

endmodule

`default_nettype wire

### rtl/blpg_back.sv
`default_nettype none
`include "bresenham_line_pixel_generator_unit_assert.svh"

module blpg_back
	import blpg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         pop_valid,
	output logic              pop,
	input  wire blpg_entry_t  pop_entry,
	output logic              pix_valid,
	input  wire logic         pix_ready,
	output blpg_pix_t         pix
);

	logic                    active_q;
	blpg_entry_t             line_q;
	logic [COL_W-1:0]        left_q;
	logic                    pix_valid_q;
	blpg_pix_t               pix_q;

	blpg_entry_t             cur;
	logic [COL_W-1:0]        left;
	logic                    run;
	logic                    emit;
	logic                    minor_step;
	logic [COL_W-1:0]        col_inc;
	logic [ROW_W-1:0]        row_inc;
	logic [COL_W-1:0]        col_next;
	logic [ROW_W-1:0]        row_next;
	logic signed [ERR_W-1:0] err_next;
	logic [COL_W-1:0]        left_next;
	blpg_entry_t             line_next;

	assign pop       = pop_valid && (!pix_valid_q || pix_ready);
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	// Pick the line being drawn: a fresh command or the held one.
	always_comb begin
		if (pop_entry.is_line) begin
			cur  = pop_entry;
			left = pop_entry.major;
			run  = (pop_entry.major != '0);
		end else begin
			cur  = line_q;
			left = left_q;
			run  = active_q;
		end
		emit = pop && run;
	end

	// One Bresenham step from the current pixel.
	always_comb begin
		minor_step = !cur.err[ERR_W-1];
		col_inc    = !cur.col_nz ? '0 : (cur.col_neg ? '1 : COL_W'(1));
		row_inc    = !cur.row_nz ? '0 : (cur.row_neg ? '1 : ROW_W'(1));
		col_next   = cur.col;
		row_next   = cur.row;
		if (cur.steep) begin
			row_next = cur.row + row_inc;
			if (minor_step) begin
				col_next = cur.col + col_inc;
			end
		end else begin
			col_next = cur.col + col_inc;
			if (minor_step) begin
				row_next = cur.row + row_inc;
			end
		end
		err_next  = cur.err + ERR_W'({cur.minor, 1'b0})
			- (minor_step ? ERR_W'({cur.major, 1'b0}) : '0);
		left_next = left - COL_W'(1);
		line_next     = cur;
		line_next.col = col_next;
		line_next.row = row_next;
		line_next.err = err_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				active_q <= (left_next != '0);
			end else if (pop && pop_entry.is_line) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			line_q <= line_next;
			left_q <= left_next;
			pix_q  <= '{pixel_x: cur.col, pixel_y: cur.row,
				pixel_colour: cur.colour, last: (left == COL_W'(1))};
		end
	end

	`BLPG_ASSERT_NOW(a_active_left, active_q, left_q != '0, "active line with no pixels left")
	`BLPG_ASSERT_NEXT(a_last_ends, emit && (left == COL_W'(1)), !active_q, "line runs past last")
	`BLPG_ASSERT_NEXT(a_emit_shows, emit, pix_valid_q, "emitted pixel not presented")

endmodule

`default_nettype wire

### rtl/bresenham_line_pixel_generator_unit.sv
// Bresenham line rasterizer: one pixel per clock once a line is loaded, while
// advances arrive and pix_ready is high. A cmd transaction passes through the
// decode register, the queue and the output register before it shows on pix.
// Throughput: one cmd and (on an active line) one pix per cycle, pix_ready high.
// Reset (arst_n low, asynchronous): no line active, queue empty, pix_valid low.
`default_nettype none

module bresenham_line_pixel_generator_unit
	import blpg_pkg::*;
#(
	// Entries in the queue between the decode front and the stepping back.
	parameter int unsigned QUEUE_DEPTH = BLPG_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  wire blpg_cmd_t  cmd,
	output logic            pix_valid,
	input  wire logic       pix_ready,
	output blpg_pix_t       pix
);

	// Front to queue.
	logic        push_valid;
	logic        push_ready;
	blpg_entry_t push_entry;

	// Queue to back.
	logic        pop_valid;
	logic        pop;
	blpg_entry_t pop_entry;

	// Front: take each transaction, work out the deltas, the octant and the
	// starting error term of a line command, and hold the decoded item in
	// one register stage. Advance transactions share that decode, with is_line clear.
	blpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Queue: decouple decode from stepping so a stalled pixel consumer
	// does not stop the front from taking transactions until it fills.
	blpg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	// Back: hold the active line, emit the current pixel into the output
	// register and advance the error term and coordinates, one item a cycle
	// unless a held pixel waits on pix_ready. A new line command drops any line
	// still in progress; an advance with no line active is consumed without a pixel.
	blpg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix)
	);

endmodule

`default_nettype wire

### dv/bresenham_line_pixel_generator_unit_tb.sv
`timescale 1ns / 1ps

module bresenham_line_pixel_generator_unit_tb
	import blpg_pkg::*;
();

	localparam int COL_MAX = (1 << COL_W) - 1;
	localparam int ROW_MAX = (1 << ROW_W) - 1;
	localparam int MAX_REPORTS = 10;
	// The limit leaves a wide margin over the run, even with every stall and gap.
	localparam int CYCLE_LIMIT = 200000;
	localparam int TARGET_ITEMS = 650;
	localparam int DRAIN_CYCLES = 20;

	// Line stepper mirror plus the queue of pixels still owed by the block.
	class pixel_scoreboard;
		blpg_pix_t expected_pixels[$];
		int mismatches;
		int pixels_checked;

		bit line_active;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col_step;
		logic [ROW_W-1:0] row_step;
		int major;
		int minor;
		bit steep;
		int err;
		int pixels_left;
		logic [CLR_W-1:0] colour;

		function new();
			line_active = 1'b0;
			col = '0;
			row = '0;
			col_step = '0;
			row_step = '0;
			major = 0;
			minor = 0;
			steep = 1'b0;
			err = 0;
			pixels_left = 0;
			colour = '0;
			mismatches = 0;
			pixels_checked = 0;
		endfunction

		// Queue the current pixel, then take one Bresenham step.
		function void step_pixel();
			blpg_pix_t p;
			p.pixel_x = col;
			p.pixel_y = row;
			p.pixel_colour = colour;
			p.last = (pixels_left == 1);
			expected_pixels.push_back(p);
			if (err >= 0) begin
				if (steep)
					col = col + col_step;
				else
					row = row + row_step;
				err = err - 2 * major;
			end
			if (steep)
				row = row + row_step;
			else
				col = col + col_step;
			err = err + 2 * minor;
			pixels_left = (pixels_left - 1) & COL_MAX;
			line_active = (pixels_left != 0);
		endfunction

		function void note_transaction(blpg_cmd_t c);
			int dx;
			int dy;
			int adx;
			int ady;
			if (c.kind == KIND_LINE) begin
				dx = int'(c.end_x) - int'(c.start_x);
				dy = int'(c.end_y) - int'(c.start_y);
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				col = c.start_x;
				row = c.start_y;
				col_step = (dx < 0) ? '1 : ((dx > 0) ? COL_W'(1) : '0);
				row_step = (dy < 0) ? '1 : ((dy > 0) ? ROW_W'(1) : '0);
				colour = c.palette_index;
				steep = (ady > adx);
				major = steep ? ady : adx;
				minor = steep ? adx : ady;
				err = 2 * minor - major;
				pixels_left = major;
				line_active = (major != 0);
				if (line_active)
					step_pixel();
			end else if (line_active) begin
				step_pixel();
			end
		endfunction

		function void check_pixel(blpg_pix_t got);
			blpg_pix_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected pixel: x=%0d y=%0d colour=%0d last=%0d",
						got.pixel_x, got.pixel_y, got.pixel_colour, got.last);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
					got.pixel_colour !== want.pixel_colour || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("pixel %0d mismatch: expected x=%0d y=%0d colour=%0d last=%0d",
						pixels_checked, want.pixel_x, want.pixel_y, want.pixel_colour,
						want.last);
					$display("  got x=%0d y=%0d colour=%0d last=%0d",
						got.pixel_x, got.pixel_y, got.pixel_colour, got.last);
				end
			end
			pixels_checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	blpg_cmd_t cmd = '0;
	logic pix_valid;
	logic pix_ready = 1'b0;
	blpg_pix_t pix;

	pixel_scoreboard sb = new();

	// Idle odds in percent per cycle; dropped to zero for a quiet stretch.
	int send_idle_pct = 6;
	int recv_stall_pct = 6;
	int items_counted = 0;
	int cycle_count = 0;

	bresenham_line_pixel_generator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	always #4 clk = ~clk;

	// Check every accepted pixel against the oldest prediction, then pick
	// the next cycle's ready. The check reads pix_ready before the update.
	always @(posedge clk) begin
		if (arst_n && pix_valid && pix_ready)
			sb.check_pixel(pix);
		pix_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Offer one transaction, hold it until accepted, then feed the predictor.
	// Only line commands and advances on an active line count toward the target.
	task automatic push_cmd(blpg_cmd_t c);
		bit counts;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		counts = (c.kind == KIND_LINE) || sb.line_active;
		sb.note_transaction(c);
		if (counts)
			items_counted++;
		// Keep the quiet stretch free of gaps and stalls on both sides.
		if (items_counted >= 250 && items_counted < 400) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end else begin
			send_idle_pct = 6;
			recv_stall_pct = 6;
		end
	endtask

	function automatic blpg_cmd_t random_cmd();
		blpg_cmd_t c;
		c.kind = 1'($urandom_range(1));
		c.start_x = COL_W'($urandom_range(COL_MAX));
		c.start_y = ROW_W'($urandom_range(ROW_MAX));
		c.end_x = COL_W'($urandom_range(COL_MAX));
		c.end_y = ROW_W'($urandom_range(ROW_MAX));
		c.palette_index = CLR_W'($urandom_range((1 << CLR_W) - 1));
		return c;
	endfunction

	task automatic send_line(int x0, int y0, int x1, int y1, int clr);
		blpg_cmd_t c;
		c.kind = KIND_LINE;
		c.start_x = COL_W'(x0);
		c.start_y = ROW_W'(y0);
		c.end_x = COL_W'(x1);
		c.end_y = ROW_W'(y1);
		c.palette_index = CLR_W'(clr);
		push_cmd(c);
	endtask

	// Advance with random junk in the fields the block must ignore.
	task automatic send_advance();
		blpg_cmd_t c;
		c = random_cmd();
		c.kind = KIND_ADVANCE;
		push_cmd(c);
	endtask

	// Draw one line with random content; most run to the end, some are
	// abandoned early, some get surplus advances after the last pixel.
	task automatic random_line_run();
		int sx;
		int sy;
		int ex;
		int ey;
		int span;
		int adx;
		int ady;
		int major;
		int n_adv;
		int pick;
		sx = $urandom_range(COL_MAX);
		sy = $urandom_range(ROW_MAX);
		span = ($urandom_range(99) < 4) ? COL_MAX : 16;
		ex = sx + int'($urandom_range(2 * span)) - span;
		span = (span > ROW_MAX) ? ROW_MAX : span;
		ey = sy + int'($urandom_range(2 * span)) - span;
		ex = (ex < 0) ? 0 : ((ex > COL_MAX) ? COL_MAX : ex);
		ey = (ey < 0) ? 0 : ((ey > ROW_MAX) ? ROW_MAX : ey);
		adx = (ex > sx) ? ex - sx : sx - ex;
		ady = (ey > sy) ? ey - sy : sy - ey;
		major = (adx > ady) ? adx : ady;
		n_adv = (major > 0) ? major - 1 : 0;
		pick = $urandom_range(99);
		if (pick >= 88)
			n_adv = n_adv + $urandom_range(1, 3);
		else if (pick >= 75 && n_adv > 0)
			n_adv = $urandom_range(n_adv - 1);
		send_line(sx, sy, ex, ey, $urandom_range((1 << CLR_W) - 1));
		repeat (n_adv)
			send_advance();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Advance with no line loaded: dropped.
		send_advance();
		// Zero-length lines at both corners of the field range: nothing drawn.
		send_line(0, 0, 0, 0, 0);
		send_advance();
		send_line(COL_MAX, ROW_MAX, COL_MAX, ROW_MAX, 255);
		// Full field diagonal past the screen edge, abandoned by the next command.
		send_line(0, 0, COL_MAX, ROW_MAX, 255);
		send_advance();
		send_advance();
		send_line(COL_MAX, ROW_MAX, 0, 0, 8'hAA);
		send_advance();
		// Steep line, then a short horizontal one drawn to the end and beyond.
		send_line(5, 0, 7, ROW_MAX, 8'h55);
		send_advance();
		send_line(10, 10, 13, 10, 1);
		send_advance();
		send_advance();
		send_advance();
		// Vertical upward.
		send_line(20, 30, 20, 27, 2);
		send_advance();
		send_advance();
		// Diagonal toward the origin from the screen corner.
		send_line(799, 479, 796, 476, 3);
		send_advance();
		send_advance();
		// Steep with negative column step.
		send_line(100, 100, 98, 105, 4);
		repeat (4)
			send_advance();
		// One-pixel line: first pixel is also the last.
		send_line(3, 3, 4, 3, 5);
		send_advance();

		// Random part: mostly well-formed lines, some raw noise.
		while (items_counted < TARGET_ITEMS) begin
			if ($urandom_range(99) < 85) begin
				random_line_run();
			end else if ($urandom_range(1) == 1) begin
				push_cmd(random_cmd());
			end else begin
				repeat ($urandom_range(1, 3))
					send_advance();
			end
		end
		cmd_valid <= 1'b0;

		// Drain owed pixels, then watch a little longer for strays.
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/blpg_pkg.sv
rtl/blpg_front.sv
rtl/blpg_queue.sv
rtl/blpg_back.sv
rtl/bresenham_line_pixel_generator_unit.sv
dv/bresenham_line_pixel_generator_unit_tb.sv
